FILE: sv/pnc_pkg.sv
// Shared types, constants and helper functions of the palette snap unit.
// Depends on nothing; pnc_dist, the top level and the testbench import it.
`timescale 1ns / 1ps

package pnc_pkg;

  localparam int DIST_W = 20;

  // Function codes of an input transaction.
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_SNAP = 2'd1;
  localparam logic [1:0] FUNC_GREY = 2'd2;

  // Configuration register indexes.
  localparam logic REG_PALETTE_COUNT = 1'b0;
  localparam logic REG_GREY_SPREAD   = 1'b1;

  localparam logic [7:0] GREY_SPREAD_RST = 8'd8;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  entry_index;
    logic [23:0] color;
  } pnc_in_t;

  typedef struct packed {
    logic [23:0] snapped_color;
    logic [7:0]  chosen_index;
    logic        from_palette;
  } pnc_out_t;

  // One scored palette entry leaving the distance stage.
  typedef struct packed {
    logic              valid;
    logic              neutral;
    logic [DIST_W-1:0] score;
    logic [23:0]       color;
  } pnc_cand_t;

  // Largest channel minus smallest channel.
  function automatic logic [7:0] spread_of(input logic [23:0] c);
    logic [7:0] r, g, b, hi, lo;
    r  = c[23:16];
    g  = c[15:8];
    b  = c[7:0];
    hi = (r > g) ? r : g;
    lo = (r < g) ? r : g;
    if (b > hi) hi = b;
    if (b < lo) lo = b;
    return hi - lo;
  endfunction

endpackage

FILE: sv/pnc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module pnc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/pnc_dist.sv
// Distance stage: squares the channel differences of one palette entry
// against the request, registers them and forms the weighted sum.
// Depends on pnc_pkg.
`timescale 1ns / 1ps

module pnc_dist
  import pnc_pkg::*;
#(
  parameter int IW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_v,
  input  logic [IW-1:0] in_idx,
  input  logic [23:0]   req_color,
  input  logic [23:0]   entry_color,
  input  logic [7:0]    grey_spread,
  output pnc_cand_t     cand,
  output logic [IW-1:0] cand_idx
);

  logic          v_r;
  logic [IW-1:0] idx_r;
  logic [15:0]   sq_r_r, sq_g_r, sq_b_r;
  logic          neu_r;
  logic [23:0]   col_r;

  function automatic logic [15:0] sqdiff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= in_idx;
    col_r  <= entry_color;
    neu_r  <= (spread_of(entry_color) <= grey_spread);
    sq_r_r <= sqdiff(req_color[23:16], entry_color[23:16]);
    sq_g_r <= sqdiff(req_color[15:8], entry_color[15:8]);
    sq_b_r <= sqdiff(req_color[7:0], entry_color[7:0]);
  end

  // Weights 3, 6 and 1 as shift-and-add.
  always_comb begin
    cand.valid   = v_r;
    cand.neutral = neu_r;
    cand.color   = col_r;
    cand.score   = DIST_W'(sq_r_r) + DIST_W'({sq_r_r, 1'b0})
                 + DIST_W'({sq_g_r, 2'b0}) + DIST_W'({sq_g_r, 1'b0})
                 + DIST_W'(sq_b_r);
  end
  assign cand_idx = idx_r;

endmodule

FILE: sv/palette_nearest_color_snap_unit.sv
// Top level of the palette snap unit: control sequencer, best-match tracking.
// Depends on pnc_pkg, pnc_ram and pnc_dist.
`timescale 1ns / 1ps

// Usage
// The input channel is a command interface: a transaction is taken at a rising
// clock edge where start is high and busy is low. A load transaction (func 0)
// writes one palette entry into the palette memory at that edge and gives no
// result; func 3 is dropped. A snap transaction (func 1 or 2) scans palette
// slots 0 to n-1, where n is palette_count clamped to PALETTE_DEPTH.
// The scan issues one memory read per cycle. Each entry is scored by a
// two-stage distance pipe, and the best overall entry and the best neutral
// entry are kept side by side, so even a grey-preserving snap needs one pass.
// When a snap ends, out_valid rises and busy drops in the same cycle, so the
// next transaction may be started while the result is shown. The memory read
// port sets the pace: one entry a cycle. With an empty palette the request
// comes back in the cycle right after the accepting edge. Each result is
// shown for exactly one cycle with out_valid; the receiver cannot stall it.
// Configuration writes (cfg_we) take effect at once and are to be made only
// while the unit is idle; the unit does not enforce this. Reset clears the
// control state and sets palette_count to 0 and grey_spread to 8; palette
// memory contents are undefined until loaded, and no clearing pass is run.

module palette_nearest_color_snap_unit
  import pnc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pnc_in_t  in_item,
  output logic     out_valid,
  output pnc_out_t out_item,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [8:0] cfg_wdata
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int NB = $clog2(PALETTE_DEPTH + 1);
  localparam int CW = (NB > 9) ? NB : 9;
  localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [8:0] count_r;
  logic [7:0] grey_r;

  // Latched request.
  logic [1:0]    func_r;
  logic [23:0]   req_r;
  logic          req_neu_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] cnt_r;

  // Read pipeline tracking.
  logic          iss_v_r;
  logic [AW-1:0] iss_idx_r;

  // Best overall and best neutral entry.
  logic              all_found_r, neu_found_r;
  logic [DIST_W-1:0] all_d_r, neu_d_r;
  logic [AW-1:0]     all_idx_r, neu_idx_r;
  logic [23:0]       all_col_r, neu_col_r;
  logic              all_neu_r;

  logic     out_valid_r;
  pnc_out_t out_item_r;

  logic          accept;
  logic [CW-1:0] n_now;
  logic          ram_we, ram_re;
  logic [23:0]   ram_rdata;
  pnc_cand_t     cand;
  logic [AW-1:0] cand_idx;
  logic          last_issue;
  logic          drained;
  logic          use_neu;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign n_now     = (CW'(count_r) > DEPTH_C) ? DEPTH_C : CW'(count_r);
  assign ram_we    = accept && (in_item.func == FUNC_LOAD) &&
                     (32'(in_item.entry_index) < PALETTE_DEPTH);
  assign ram_re    = (state_r == ST_SCAN);
  assign last_issue = (cnt_r == n_r - CW'(1));
  assign drained   = !iss_v_r && !cand.valid;
  assign use_neu   = (func_r == FUNC_GREY) && req_neu_r && !all_neu_r && neu_found_r;

  pnc_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_item.entry_index)),
    .wdata(in_item.color),
    .re   (ram_re),
    .raddr(cnt_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  pnc_dist #(
    .IW(AW)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_v       (iss_v_r),
    .in_idx     (iss_idx_r),
    .req_color  (req_r),
    .entry_color(ram_rdata),
    .grey_spread(grey_r),
    .cand       (cand),
    .cand_idx   (cand_idx)
  );

  // Sequencer: a snap with a nonempty palette scans, then waits for the
  // distance pipe to empty before the result is registered.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && ((in_item.func == FUNC_SNAP) || (in_item.func == FUNC_GREY)) &&
            (n_now != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drained) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      grey_r      <= GREY_SPREAD_RST;
      iss_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      all_found_r <= 1'b0;
      neu_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_v_r     <= ram_re;
      // A result is strobed for an empty-palette snap or at the end of a scan.
      out_valid_r <= (accept && ((in_item.func == FUNC_SNAP) ||
                                 (in_item.func == FUNC_GREY)) && (n_now == '0)) ||
                     ((state_r == ST_DRAIN) && drained);

      if (cfg_we) begin
        unique case (cfg_index)
          REG_PALETTE_COUNT: count_r <= cfg_wdata;
          REG_GREY_SPREAD:   grey_r  <= cfg_wdata[7:0];
          default:           ;
        endcase
      end

      if (accept) begin
        all_found_r <= 1'b0;
        neu_found_r <= 1'b0;
      end else if (cand.valid) begin
        if (!all_found_r || (cand.score < all_d_r)) begin
          all_found_r <= 1'b1;
        end
        if (cand.neutral && (!neu_found_r || (cand.score < neu_d_r))) begin
          neu_found_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    iss_idx_r <= cnt_r[AW-1:0];

    if (accept) begin
      func_r    <= in_item.func;
      req_r     <= in_item.color;
      req_neu_r <= (spread_of(in_item.color) <= grey_r);
      n_r       <= n_now;
      cnt_r     <= '0;
      // Empty palette: the request passes through.
      out_item_r.snapped_color <= in_item.color;
      out_item_r.chosen_index  <= 8'd0;
      out_item_r.from_palette  <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      cnt_r <= cnt_r + CW'(1);
    end

    if (!accept && cand.valid) begin
      // Strict compare keeps the lowest index on a tie.
      if (!all_found_r || (cand.score < all_d_r)) begin
        all_d_r   <= cand.score;
        all_idx_r <= cand_idx;
        all_col_r <= cand.color;
        all_neu_r <= cand.neutral;
      end
      if (cand.neutral && (!neu_found_r || (cand.score < neu_d_r))) begin
        neu_d_r   <= cand.score;
        neu_idx_r <= cand_idx;
        neu_col_r <= cand.color;
      end
    end

    if ((state_r == ST_DRAIN) && drained) begin
      out_item_r.snapped_color <= use_neu ? neu_col_r : all_col_r;
      out_item_r.chosen_index  <= use_neu ? 8'(neu_idx_r) : 8'(all_idx_r);
      out_item_r.from_palette  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The memory is written only when idle and read only while scanning.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("palette memory written during a scan");

  // The scan address never reaches the clamped entry count.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r < n_r))
    else $error("scan address beyond palette count");

  // No entry is in flight through the read or distance pipe when idle.
  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!iss_v_r && !cand.valid))
    else $error("distance pipe active while idle");

  // A scan result always carries a found entry.
  a_found_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DRAIN) && drained) |-> all_found_r)
    else $error("scan finished without a candidate");

endmodule

FILE: dv/tb_palette_nearest_color_snap_unit.sv
// Self-checking testbench for palette_nearest_color_snap_unit: palette loads, nearest and
// grey-preserving snaps, driven directed and then at random. Depends on pnc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_palette_nearest_color_snap_unit;
  import pnc_pkg::*;

  localparam int PALETTE_SLOTS = 256;
  localparam int RANDOM_ITEMS  = 600;
  // A full-palette snap and the longest sender gap both fit well inside this limit,
  // so a quiet stretch this long can only mean a hang.
  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = PALETTE_SLOTS + 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;
  // The package names no code for the unused function value.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Keeps a private copy of the palette and the two registers, predicts the result of
  // every accepted snap transaction and compares results in arrival order.
  class palette_snap_board;
    bit [23:0]   palette [PALETTE_SLOTS];
    bit          loaded [PALETTE_SLOTS];
    int unsigned count = 0;
    int unsigned spread = 32'(GREY_SPREAD_RST);
    pnc_out_t    expected_snaps [$];
    int          mismatches = 0;

    // Difference between the strongest and the weakest channel of a color.
    function int unsigned channel_range(bit [23:0] c);
      int unsigned r, g, b, top, bottom;
      r = 32'(c[23:16]);
      g = 32'(c[15:8]);
      b = 32'(c[7:0]);
      top = r;
      bottom = r;
      if (g > top) top = g;
      if (g < bottom) bottom = g;
      if (b > top) top = b;
      if (b < bottom) bottom = b;
      return top - bottom;
    endfunction

    function int unsigned weighted_dist(bit [23:0] a, bit [23:0] b);
      int dr, dg, db;
      dr = int'(a[23:16]) - int'(b[23:16]);
      dg = int'(a[15:8]) - int'(b[15:8]);
      db = int'(a[7:0]) - int'(b[7:0]);
      return 3 * dr * dr + 6 * dg * dg + db * db;
    endfunction

    // Lowest slot below n with the smallest distance; -1 when no slot qualifies.
    function int closest_slot(bit [23:0] want, int unsigned n, bit greys_only);
      int          pick;
      int unsigned d, best;
      pick = -1;
      best = 0;
      for (int i = 0; i < n; i++) begin
        if (greys_only && channel_range(palette[i]) > spread) continue;
        d = weighted_dist(want, palette[i]);
        if (pick < 0 || d < best) begin
          best = d;
          pick = i;
        end
      end
      return pick;
    endfunction

    function pnc_out_t predict_snap(logic [1:0] func, bit [23:0] want);
      pnc_out_t    res;
      int unsigned n;
      int          pick, grey_pick;
      n = (count > PALETTE_SLOTS) ? PALETTE_SLOTS : count;
      res = '0;
      if (n == 0) begin
        res.snapped_color = want;
      end else begin
        pick = closest_slot(want, n, 1'b0);
        // A neutral request must not be pulled onto a tinted entry if a neutral one exists.
        if (func == FUNC_GREY && channel_range(want) <= spread &&
            channel_range(palette[pick]) > spread) begin
          grey_pick = closest_slot(want, n, 1'b1);
          if (grey_pick >= 0) pick = grey_pick;
        end
        res.snapped_color = palette[pick];
        res.chosen_index  = pick[7:0];
        res.from_palette  = 1'b1;
      end
      return res;
    endfunction

    function void accept_cmd(pnc_in_t cmd);
      case (cmd.func)
        FUNC_LOAD: begin
          palette[cmd.entry_index] = cmd.color;
          loaded[cmd.entry_index] = 1'b1;
        end
        FUNC_SNAP, FUNC_GREY: begin
          expected_snaps.push_back(predict_snap(cmd.func, cmd.color));
        end
        default: begin
        end
      endcase
    endfunction

    function void write_reg(logic idx, logic [8:0] val);
      if (idx == REG_PALETTE_COUNT) count = 32'(val);
      else spread = 32'(val[7:0]);
    endfunction

    function void check_snap(pnc_out_t got);
      pnc_out_t want;
      if (expected_snaps.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing expected: color=%06h index=%0d from_palette=%0b",
                   $time, got.snapped_color, got.chosen_index, got.from_palette);
      end else begin
        want = expected_snaps.pop_front();
        if (got.snapped_color !== want.snapped_color || got.chosen_index !== want.chosen_index ||
            got.from_palette !== want.from_palette) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"%0t: snap mismatch: expected color=%06h index=%0d from_palette=%0b,",
                      " got color=%06h index=%0d from_palette=%0b"}, $time,
                     want.snapped_color, want.chosen_index, want.from_palette,
                     got.snapped_color, got.chosen_index, got.from_palette);
        end
      end
    endfunction

    function int pending();
      return expected_snaps.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  pnc_in_t    in_item = '0;
  logic       out_valid;
  pnc_out_t   out_item;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [8:0] cfg_wdata = '0;
  int         quiet_cycles = 0;
  int         stim_items = 0;
  palette_snap_board board;

  palette_nearest_color_snap_unit #(
    .PALETTE_DEPTH(PALETTE_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results cannot be held off, so every strobed cycle is one result transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) board.check_snap(out_item);
  end

  // Watchdog: any accepted transaction on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic pnc_in_t make_cmd(logic [1:0] f, logic [7:0] slot, logic [23:0] c);
    pnc_in_t cmd;
    cmd.func = f;
    cmd.entry_index = slot;
    cmd.color = c;
    return cmd;
  endfunction

  // Moves each channel by up to w steps either way, clamped to the channel range.
  function automatic logic [23:0] jitter_color(logic [23:0] c, int w);
    logic [23:0] res;
    int          v;
    for (int k = 0; k < 3; k++) begin
      v = int'(c[8*k +: 8]) + int'($urandom_range(0, 2 * w)) - w;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      res[8*k +: 8] = v[7:0];
    end
    return res;
  endfunction

  // A grey level with a small tint, so it lands on both sides of typical spread settings.
  function automatic logic [23:0] grey_color();
    logic [7:0] v;
    v = 8'($urandom);
    return jitter_color({v, v, v}, $urandom_range(0, 12));
  endfunction

  // Palette contents: many near-greys, copies of loaded entries to force distance ties,
  // saturated corners and plain random colors.
  function automatic logic [23:0] load_color();
    int slot;
    case ($urandom_range(0, 5))
      0, 1: return grey_color();
      2: begin
        slot = $urandom_range(0, PALETTE_SLOTS - 1);
        return board.loaded[slot] ? board.palette[slot] : 24'($urandom);
      end
      3: return {8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
                 8'($urandom_range(0, 1) * 255)};
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic int pick_gap(bit burst);
    return burst ? 0 : int'($urandom_range(0, 19));
  endfunction

  // Presents one command and holds it until the unit takes it. Start stays high
  // between back-to-back commands and is only lowered when a gap is drawn.
  task automatic send_item(pnc_in_t cmd, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy !== 1'b0);
    board.accept_cmd(cmd);
    if (cmd.func != FUNC_UNUSED) stim_items++;
  endtask

  // Registers only change while nothing is in flight. A load gives no result, so a
  // further SETTLE_CYCLES wait covers one that might still be settling.
  task automatic set_config(int unsigned count, int unsigned spread);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_PALETTE_COUNT;
    cfg_wdata <= count[8:0];
    @(posedge clk);
    board.write_reg(REG_PALETTE_COUNT, count[8:0]);
    cfg_index <= REG_GREY_SPREAD;
    cfg_wdata <= {1'b0, spread[7:0]};
    @(posedge clk);
    board.write_reg(REG_GREY_SPREAD, {1'b0, spread[7:0]});
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned count, spread, n, items, pick;
    int          phase_no;
    bit          burst;
    pnc_in_t     cmd;
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty palette after reset: requests come straight back, and the unused
    // function value is dropped without a result.
    send_item(make_cmd(FUNC_SNAP, 8'h00, 24'h000000), pick_gap(1'b0));
    send_item(make_cmd(FUNC_GREY, 8'hFF, 24'hFFFFFF), pick_gap(1'b0));
    send_item(make_cmd(FUNC_UNUSED, 8'hFF, 24'h123456), pick_gap(1'b0));

    // A small palette with corners, a duplicated grey for the tie rule and a tinted
    // entry that sits closer to a neutral request than any grey does.
    send_item(make_cmd(FUNC_LOAD, 8'd0, 24'hFF0000), 0);
    send_item(make_cmd(FUNC_LOAD, 8'd1, 24'h808080), 0);
    send_item(make_cmd(FUNC_LOAD, 8'd2, 24'h000000), 0);
    send_item(make_cmd(FUNC_LOAD, 8'd3, 24'hFFFFFF), 0);
    send_item(make_cmd(FUNC_LOAD, 8'd4, 24'h00FF00), pick_gap(1'b0));
    send_item(make_cmd(FUNC_LOAD, 8'd5, 24'h0000FF), pick_gap(1'b0));
    send_item(make_cmd(FUNC_LOAD, 8'd6, 24'h808080), 0);
    send_item(make_cmd(FUNC_LOAD, 8'd7, 24'hA08888), 0);
    send_item(make_cmd(FUNC_LOAD, 8'hFF, 24'h5A5A5A), pick_gap(1'b0));

    set_config(8, 8);
    // Exact match on two slots: the lower one must win.
    send_item(make_cmd(FUNC_SNAP, 8'h00, 24'h808080), 0);
    // Neutral request whose nearest entry is tinted: the grey snap falls back to a grey
    // entry while the plain snap keeps the tinted one.
    send_item(make_cmd(FUNC_GREY, 8'h00, 24'h908888), 0);
    send_item(make_cmd(FUNC_SNAP, 8'h00, 24'h908888), pick_gap(1'b0));
    send_item(make_cmd(FUNC_GREY, 8'h00, 24'hFFFFFF), 0);
    send_item(make_cmd(FUNC_SNAP, 8'h00, 24'h0000FE), pick_gap(1'b0));

    // One tinted entry and a zero spread: the grey search finds no neutral entry,
    // so the plain nearest entry stands.
    set_config(1, 0);
    send_item(make_cmd(FUNC_GREY, 8'h00, 24'h000000), 0);
    send_item(make_cmd(FUNC_SNAP, 8'h00, 24'h7F7F7F), 0);

    // Largest spread: every color counts as neutral, so nothing is re-searched.
    set_config(8, 255);
    send_item(make_cmd(FUNC_GREY, 8'h00, 24'h908888), 0);

    // Palette loaded but disabled again: pass-through.
    set_config(0, 8);
    send_item(make_cmd(FUNC_GREY, 8'h00, 24'h808080), 0);

    // Random phases. Each phase picks a register setting, fills any slot that the new
    // count would expose before it was ever loaded, then mixes snaps, loads and a few
    // dropped commands. Phases 1 and 4 force the full and the oversized count.
    stim_items = 0;
    phase_no = 0;
    while (stim_items < RANDOM_ITEMS) begin
      if (phase_no == 1) count = PALETTE_SLOTS;
      else if (phase_no == 4) count = 511;
      else begin
        case ($urandom_range(0, 9))
          0: count = 0;
          1: count = $urandom_range(PALETTE_SLOTS, 511);
          default: count = $urandom_range(1, 16);
        endcase
      end
      case ($urandom_range(0, 7))
        0: spread = 0;
        1: spread = 255;
        2: spread = $urandom_range(0, 255);
        default: spread = $urandom_range(0, 24);
      endcase
      set_config(count, spread);
      n = (count > PALETTE_SLOTS) ? PALETTE_SLOTS : count;
      burst = ($urandom_range(0, 3) == 0);

      for (int s = 0; s < n; s++) begin
        if (!board.loaded[s]) send_item(make_cmd(FUNC_LOAD, s[7:0], load_color()),
                                        pick_gap(burst));
      end

      // Snaps over a large palette take long, so those phases stay short.
      items = (n > 16) ? $urandom_range(6, 12) : $urandom_range(20, 60);
      repeat (items) begin
        pick = $urandom_range(0, 99);
        cmd.entry_index = 8'($urandom);
        cmd.color = 24'($urandom);
        if (pick < 5) begin
          cmd.func = FUNC_UNUSED;
        end else if (pick < 30) begin
          cmd.func = FUNC_LOAD;
          cmd.color = load_color();
        end else begin
          cmd.func = pick[0] ? FUNC_GREY : FUNC_SNAP;
          // Requests near live entries give close calls and exact ties.
          case ($urandom_range(0, 3))
            0: begin
            end
            1: cmd.color = grey_color();
            default: begin
              if (n > 0)
                cmd.color = jitter_color(board.palette[$urandom_range(0, n - 1)],
                                         $urandom_range(0, 6));
            end
          endcase
        end
        send_item(cmd, pick_gap(burst));
      end
      phase_no++;
    end

    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pnc_pkg.sv
sv/pnc_ram.sv
sv/pnc_dist.sv
sv/palette_nearest_color_snap_unit.sv
dv/tb_palette_nearest_color_snap_unit.sv
